FILE: src/ias_pkg.sv
// Shared types and constants for the integer array sorter.
// Depends on nothing; every other file imports it.
package ias_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_flag;
        logic                      overflow;
    } t_out_word;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the incoming value at its sorted place
        logic pop;   // shift the whole row one place towards cell 0
    } t_chain_cmd;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

FILE: src/integer_array_sorter.sv
// Integer array sorter: a row of DEPTH insertion cells sorts each block as it loads.
// Loading takes one word per cycle; after the closing word is accepted the state register enters
// emission; then cell 0 of the row feeds one sorted word per cycle into the output register,
// while out is not stalled. The input is stalled for all of the emission of a block.
// Reset (synchronous, active low) empties the row, clears the count and overflow mark.
// Depends on ias_pkg and ias_cell.
module integer_array_sorter
    import ias_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_count;
    logic                      r_drop;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic                      in_acc;
    logic                      out_free;
    logic                      full;
    logic                      last_pop;
    t_chain_cmd                cmd;

    logic signed [VALUE_W-1:0] w_value [DEPTH];
    logic                      w_valid [DEPTH];
    logic                      w_gt    [DEPTH];

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_count == CNT_W'(DEPTH));
    assign last_pop = cmd.pop && (r_count == CNT_W'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_in_data.block_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (last_pop) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs of the controller
    always_comb begin
        o_in_stall = 1'b1;
        cmd.ins    = 1'b0;
        cmd.pop    = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                cmd.ins    = i_in_valid && !full;
            end
            ST_EMIT: begin
                cmd.pop = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            // Mark the block once a word finds the row full; drop after its last word
            if (in_acc && full) begin
                r_drop <= 1'b1;
            end else if (last_pop) begin
                r_drop <= 1'b0;
            end
            if (cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.pop) begin
            r_out.sorted_value <= w_value[0];
            r_out.final_flag   <= (r_count == CNT_W'(1));
            r_out.overflow     <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_valid;
        logic                      prev_gt;
        logic signed [VALUE_W-1:0] next_value;
        logic                      next_valid;

        if (g == 0) begin : g_head
            assign prev_value = '0;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_value = w_value[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_gt    = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_value = w_value[g+1];
            assign next_valid = w_valid[g+1];
        end

        ias_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_new_value  (i_in_data.sample_value),
            .i_prev_value (prev_value),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_value (next_value),
            .i_next_valid (next_valid),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("emission with an empty row");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("word count beyond capacity");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == (r_count != '0))
        else $error("head cell disagrees with word count");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |=> o_out_valid)
        else $error("popped word not presented");

endmodule

FILE: src/ias_cell.sv
// One cell of the insertion chain: holds one value and its valid bit.
// Depends on ias_pkg.
module ias_cell
    import ias_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_chain_cmd                i_cmd,
    input  logic signed [VALUE_W-1:0] i_new_value,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic                      i_prev_valid,
    input  logic                      i_prev_gt,
    input  logic signed [VALUE_W-1:0] i_next_value,
    input  logic                      i_next_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_valid,
    output logic                      o_gt
);

    logic signed [VALUE_W-1:0] r_value;
    logic                      r_valid;
    logic signed [VALUE_W-1:0] n_value;
    logic                      n_valid;

    // An empty cell counts as larger than anything; equal values stay ahead
    assign o_gt    = !r_valid || (r_value > i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.pop) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_cmd.ins && o_gt) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: verif/integer_array_sorter_tb.sv
// Self-checking bench for integer_array_sorter: drives blocks of signed words, predicts
// the sorted stream and compares every result word field by field.
// Depends on ias_pkg and the integer_array_sorter RTL.
module integer_array_sorter_tb;
    import ias_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int N_DIRECTED  = 24;
    localparam int RANDOM_WORDS = 196;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        t_in_word  word;
        logic      typed;   // want holds a hand-written result
        t_out_word want;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;

    // sorted copy of the words held for the open block
    logic signed [VALUE_W-1:0] held_sorted[$];
    logic      held_dropped = 1'b0;
    t_out_word expected_words[$];

    t_row directed_rows [N_DIRECTED];
    int   cycle_count     = 0;
    int   fail_count      = 0;
    int   words_sent      = 0;
    int   results_checked = 0;
    int   blocks_closed   = 0;
    int   overflow_blocks = 0;
    int   burst_left      = 0;
    logic drv_valid       = 1'b0;
    int   stall_window    = 0;
    int   stall_mode      = 0;

    integer_array_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_words.size());
            $display("integer_array_sorter regression: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    function automatic t_row mk_row(input logic signed [VALUE_W-1:0] v, input logic last,
                                    input logic typed);
        t_row r;
        r.word.sample_value = v;
        r.word.block_end    = last;
        r.typed             = typed;
        // a lone word comes back as itself, marked final, no overflow
        r.want.sorted_value = v;
        r.want.final_flag   = 1'b1;
        r.want.overflow     = 1'b0;
        return r;
    endfunction

    // Insert the accepted word into the held set; on block end release the sorted set.
    task automatic absorb_word(input t_in_word w, input logic typed, input t_out_word want);
        int        pos = 0;
        t_out_word res;
        if (held_sorted.size() < DEPTH) begin
            while (pos < held_sorted.size() && held_sorted[pos] <= w.sample_value)
                pos++;
            held_sorted.insert(pos, w.sample_value);
        end else begin
            held_dropped = 1'b1;
        end
        if (w.block_end) begin
            blocks_closed++;
            if (held_dropped)
                overflow_blocks++;
            if (typed) begin
                expected_words.push_back(want);
            end else begin
                foreach (held_sorted[k]) begin
                    res.sorted_value = held_sorted[k];
                    res.final_flag   = (k == held_sorted.size() - 1);
                    res.overflow     = held_dropped;
                    expected_words.push_back(res);
                end
            end
            held_sorted.delete();
            held_dropped = 1'b0;
        end
    endtask

    // Offer one word, hold it until taken, then maybe drop valid for a gap.
    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        drv_valid  = 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        words_sent++;
        absorb_word(w, typed, want);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                drv_valid  = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel = $urandom_range(0, 5);
        case (sel)
            1: return $signed($urandom_range(0, 8)) - 4;   // crowd duplicates
            2: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MIN + 1;
                    2: return VAL_MAX;
                    3: return VAL_MAX - 1;
                    4: return 0;
                    default: return -1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    // Check each result word against the oldest expectation; vary the stall pattern.
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %0d", o_out_data.sorted_value));
            end else begin
                want = expected_words.pop_front();
                results_checked++;
                if (o_out_data.sorted_value !== want.sorted_value)
                    flag_mismatch($sformatf("sorted_value %0d, want %0d",
                                            o_out_data.sorted_value, want.sorted_value));
                if (o_out_data.final_flag !== want.final_flag)
                    flag_mismatch($sformatf("final_flag %b, want %b on value %0d",
                                            o_out_data.final_flag, want.final_flag,
                                            want.sorted_value));
                if (o_out_data.overflow !== want.overflow)
                    flag_mismatch($sformatf("overflow %b, want %b on value %0d",
                                            o_out_data.overflow, want.overflow,
                                            want.sorted_value));
            end
        end
        if (stall_window == 0) begin
            stall_window <= $urandom_range(20, 80);
            stall_mode   <= $urandom_range(0, 2);
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    initial begin : stimulus
        t_in_word  w;
        t_out_word none;
        int        blk;
        int        size;
        int        random_words;

        none = '0;
        directed_rows[0]  = mk_row(VAL_MIN,               1'b1, 1'b1);
        directed_rows[1]  = mk_row(VAL_MAX,               1'b1, 1'b1);
        directed_rows[2]  = mk_row(0,                     1'b1, 1'b1);
        directed_rows[3]  = mk_row(-1,                    1'b1, 1'b1);
        directed_rows[4]  = mk_row(1,                     1'b1, 1'b1);
        // descending extremes
        directed_rows[5]  = mk_row(VAL_MAX,               1'b0, 1'b0);
        directed_rows[6]  = mk_row(32'sh4000_0000,        1'b0, 1'b0);
        directed_rows[7]  = mk_row(0,                     1'b0, 1'b0);
        directed_rows[8]  = mk_row(-1,                    1'b0, 1'b0);
        directed_rows[9]  = mk_row(VAL_MIN,               1'b1, 1'b0);
        // duplicates kept
        directed_rows[10] = mk_row(7,                     1'b0, 1'b0);
        directed_rows[11] = mk_row(7,                     1'b0, 1'b0);
        directed_rows[12] = mk_row(-7,                    1'b0, 1'b0);
        directed_rows[13] = mk_row(7,                     1'b1, 1'b0);
        // already ascending
        directed_rows[14] = mk_row(-3,                    1'b0, 1'b0);
        directed_rows[15] = mk_row(-2,                    1'b0, 1'b0);
        directed_rows[16] = mk_row(-1,                    1'b0, 1'b0);
        directed_rows[17] = mk_row(0,                     1'b0, 1'b0);
        directed_rows[18] = mk_row(1,                     1'b0, 1'b0);
        directed_rows[19] = mk_row(2,                     1'b1, 1'b0);
        // alternating bit patterns, the second one negative
        directed_rows[20] = mk_row(32'sh5555_5555,        1'b0, 1'b0);
        directed_rows[21] = mk_row($signed(32'hAAAA_AAAA), 1'b1, 1'b0);
        directed_rows[22] = mk_row(VAL_MIN,               1'b0, 1'b0);
        directed_rows[23] = mk_row(VAL_MIN,               1'b1, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);

        // hold off until the directed results are all back
        if (drv_valid) begin
            i_in_valid <= 1'b0;
            drv_valid  = 1'b0;
        end
        wait_drained();
        @(posedge i_clk);

        // mostly short blocks; one exactly full, one losing its closing word
        blk = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if (blk == 2)
                size = DEPTH;
            else if (blk == 5)
                size = DEPTH + 1;
            else if ($urandom_range(0, 15) == 0)
                size = $urandom_range(DEPTH - 1, DEPTH + 3);
            else
                size = $urandom_range(1, 8);
            for (int k = 0; k < size; k++) begin
                w.sample_value = pick_value();
                w.block_end    = (k == size - 1);
                send_word(w, 1'b0, none);
                random_words++;
            end
            if (blk == 4) begin
                if (drv_valid) begin
                    i_in_valid <= 1'b0;
                    drv_valid  = 1'b0;
                end
                wait_drained();
                @(posedge i_clk);
            end
            blk++;
        end

        if (drv_valid) begin
            i_in_valid <= 1'b0;
            drv_valid  = 1'b0;
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words in %0d blocks (%0d with dropped words)",
                 words_sent, blocks_closed, overflow_blocks);
        $display("checked %0d sorted words, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("integer_array_sorter regression: pass");
        else
            $display("integer_array_sorter regression: fail");
        $finish;
    end

endmodule
